@@ hdl/rrq_pkg.sv @@
package rrq_pkg;

    localparam int ID_W          = 5;
    localparam int ID_COUNT      = 32;
    localparam int OP_W          = 2;
    localparam int DEF_MAX_TASKS = 32;

    localparam logic [OP_W-1:0] OP_ADD       = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE    = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_READY = 2'd2;
    localparam logic [OP_W-1:0] OP_PICK      = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic append;
        logic set_ready;
        logic ptr_zero;
        logic ptr_start;
        logic ptr_step;
        logic ptr_wrap_step;
        logic ptr_succ;
        logic pos_save;
        logic shift_wr;
        logic shrink;
        logic succ_take;
        logic pick_hit;
        logic pick_miss;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            add_ok;
        logic            rem_ok;
        logic            count_zero;
        logic            match;
        logic            at_end;
        logic            cur_hit;
        logic            last_entry;
        logic            ready_hit;
        logic            scan_last;
    } stat_t;

endpackage

@@ hdl/round_robin_run_queue_core.sv @@
// Add and set ready are handled in the dispatch state; remove searches the order store,
// compacts the entries behind the removed one and, if it was the current task, reads the
// successor; pick scans up to queue_count entries, one order-store read per scanned entry.
// One word at a time: the next word is taken in the cycle after the result is loaded
// into the output register, which may still be waiting on m_ready.
// Reset (aresetn low, synchronous) empties the queue, clears all marks and goes idle.
module round_robin_run_queue_core #(
    parameter int MAX_TASKS = rrq_pkg::DEF_MAX_TASKS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [rrq_pkg::OP_W-1:0] s_opcode,
    input  logic [rrq_pkg::ID_W-1:0] s_task_id,
    input  logic                     s_ready_flag,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [rrq_pkg::ID_W-1:0] m_chosen_task,
    output logic                     m_chosen_idle,
    output logic                     m_took_effect
);
    import rrq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    rrq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rrq_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_opcode      (s_opcode),
        .s_task_id     (s_task_id),
        .s_ready_flag  (s_ready_flag),
        .cmd           (cmd),
        .stat          (stat),
        .m_chosen_task (m_chosen_task),
        .m_chosen_idle (m_chosen_idle),
        .m_took_effect (m_took_effect)
    );

endmodule

@@ hdl/rrq_ram.sv @@
module rrq_ram #(
    parameter int WIDTH = rrq_pkg::ID_W,
    parameter int DEPTH = rrq_pkg::DEF_MAX_TASKS
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/rrq_dp.sv @@
module rrq_dp #(
    parameter int MAX_TASKS = rrq_pkg::DEF_MAX_TASKS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [rrq_pkg::OP_W-1:0]  s_opcode,
    input  logic [rrq_pkg::ID_W-1:0]  s_task_id,
    input  logic                      s_ready_flag,
    input  rrq_pkg::cmd_t             cmd,
    output rrq_pkg::stat_t            stat,
    output logic [rrq_pkg::ID_W-1:0]  m_chosen_task,
    output logic                      m_chosen_idle,
    output logic                      m_took_effect
);
    import rrq_pkg::*;

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    logic [OP_W-1:0]     op_reg;
    logic [ID_W-1:0]     id_reg;
    logic                flag_reg;
    logic [CW-1:0]       count_reg;
    logic [ID_COUNT-1:0] queued_reg;
    logic [ID_COUNT-1:0] ready_reg;
    logic [ID_W-1:0]     cur_task_reg;
    logic                cur_idle_reg;
    logic [CW-1:0]       cur_pos_reg;
    logic                effect_reg;
    logic [CW-1:0]       ptr_reg;
    logic [CW-1:0]       ptr_next;
    logic [CW-1:0]       k_reg;
    logic [CW-1:0]       pos_reg;
    logic [ID_W-1:0]     out_task_reg;
    logic                out_idle_reg;
    logic                out_effect_reg;

    logic [ID_W-1:0]     rdata;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [ID_W-1:0]     wdata;
    logic [CW-1:0]       ptr_inc;
    logic [CW-1:0]       ptr_dec;
    logic [CW-1:0]       start_pos;
    logic [CW-1:0]       cur_inc;
    logic                id_ok;

    rrq_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_TASKS)
    ) u_order (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (ptr_next[AW-1:0]),
        .rdata (rdata)
    );

    assign id_ok   = 32'(id_reg) < 32'(MAX_TASKS);
    assign ptr_inc = ptr_reg + CW'(1);
    assign ptr_dec = ptr_reg - CW'(1);
    assign cur_inc = cur_pos_reg + CW'(1);

    // A pick starts one past the current task, wrapping to the head, or at the head when no task is current.
    always_comb begin
        if (cur_idle_reg || cur_inc == count_reg) begin
            start_pos = '0;
        end else begin
            start_pos = cur_inc;
        end
    end

    always_comb begin
        priority if (cmd.ptr_zero) begin
            ptr_next = '0;
        end else if (cmd.ptr_start) begin
            ptr_next = start_pos;
        end else if (cmd.ptr_step) begin
            ptr_next = ptr_inc;
        end else if (cmd.ptr_wrap_step) begin
            ptr_next = (ptr_inc == count_reg) ? '0 : ptr_inc;
        end else if (cmd.ptr_succ) begin
            ptr_next = (pos_reg == count_reg - CW'(1)) ? '0 : pos_reg;
        end else begin
            ptr_next = ptr_reg;
        end
    end

    always_comb begin
        we    = cmd.append | cmd.shift_wr;
        waddr = cmd.append ? count_reg[AW-1:0] : ptr_dec[AW-1:0];
        wdata = cmd.append ? id_reg : rdata;
    end

    always_comb begin
        stat.op         = op_reg;
        stat.add_ok     = id_ok && !queued_reg[id_reg] && count_reg != CW'(MAX_TASKS);
        stat.rem_ok     = id_ok && queued_reg[id_reg];
        stat.count_zero = count_reg == '0;
        stat.match      = rdata == id_reg;
        stat.at_end     = ptr_reg == count_reg;
        stat.cur_hit    = !cur_idle_reg && cur_task_reg == id_reg;
        stat.last_entry = count_reg == CW'(1);
        stat.ready_hit  = ready_reg[rdata];
        stat.scan_last  = (k_reg + CW'(1)) == count_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg   <= s_opcode;
            id_reg   <= s_task_id;
            flag_reg <= s_ready_flag;
        end
        ptr_reg <= ptr_next;
        if (cmd.ptr_start) begin
            k_reg <= '0;
        end else if (cmd.ptr_wrap_step) begin
            k_reg <= k_reg + CW'(1);
        end
        if (cmd.pos_save) begin
            pos_reg <= ptr_reg;
        end
        if (cmd.out_load) begin
            out_task_reg   <= cur_task_reg;
            out_idle_reg   <= cur_idle_reg;
            out_effect_reg <= effect_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            queued_reg   <= '0;
            ready_reg    <= '0;
            cur_task_reg <= '0;
            cur_idle_reg <= 1'b1;
            cur_pos_reg  <= '0;
            effect_reg   <= 1'b0;
        end else begin
            if (cmd.load_in) begin
                effect_reg <= 1'b0;
            end
            if (cmd.append) begin
                count_reg          <= count_reg + CW'(1);
                queued_reg[id_reg] <= 1'b1;
                effect_reg         <= 1'b1;
            end
            if (cmd.set_ready && id_ok) begin
                ready_reg[id_reg] <= flag_reg;
            end
            if (cmd.shrink) begin
                count_reg          <= count_reg - CW'(1);
                queued_reg[id_reg] <= 1'b0;
                effect_reg         <= 1'b1;
                if (stat.cur_hit && stat.last_entry) begin
                    cur_idle_reg <= 1'b1;
                    cur_task_reg <= '0;
                end else if (!stat.cur_hit && !cur_idle_reg && cur_pos_reg > pos_reg) begin
                    // Entries behind the removed one move up by one place.
                    cur_pos_reg <= cur_pos_reg - CW'(1);
                end
            end
            if (cmd.succ_take || cmd.pick_hit) begin
                cur_task_reg <= rdata;
                cur_pos_reg  <= ptr_reg;
                cur_idle_reg <= 1'b0;
            end
            if (cmd.pick_hit) begin
                effect_reg <= 1'b1;
            end
            if (cmd.pick_miss) begin
                cur_task_reg <= '0;
                cur_idle_reg <= 1'b1;
            end
        end
    end

    assign m_chosen_task = out_task_reg;
    assign m_chosen_idle = out_idle_reg;
    assign m_took_effect = out_effect_reg;

endmodule

@@ hdl/rrq_ctrl.sv @@
module rrq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  rrq_pkg::stat_t stat,
    output rrq_pkg::cmd_t  cmd
);
    import rrq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_SUCC  = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP: begin
                unique case (stat.op)
                    OP_ADD: begin
                        cmd.append = stat.add_ok;
                        state_next = S_DONE;
                    end
                    OP_REMOVE: begin
                        if (stat.rem_ok) begin
                            cmd.ptr_zero = 1'b1;
                            state_next   = S_FIND;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    OP_SET_READY: begin
                        cmd.set_ready = 1'b1;
                        state_next    = S_DONE;
                    end
                    OP_PICK: begin
                        if (stat.count_zero) begin
                            cmd.pick_miss = 1'b1;
                            state_next    = S_DONE;
                        end else begin
                            cmd.ptr_start = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                endcase
            end
            S_FIND: begin
                cmd.ptr_step = 1'b1;
                if (stat.match) begin
                    cmd.pos_save = 1'b1;
                    state_next   = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (stat.at_end) begin
                    cmd.shrink = 1'b1;
                    if (stat.cur_hit && !stat.last_entry) begin
                        // The successor now sits at the removed slot, or at the head.
                        cmd.ptr_succ = 1'b1;
                        state_next   = S_SUCC;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    cmd.shift_wr = 1'b1;
                    cmd.ptr_step = 1'b1;
                end
            end
            S_SUCC: begin
                cmd.succ_take = 1'b1;
                state_next    = S_DONE;
            end
            S_SCAN: begin
                if (stat.ready_hit) begin
                    cmd.pick_hit = 1'b1;
                    state_next   = S_DONE;
                end else if (stat.scan_last) begin
                    cmd.pick_miss = 1'b1;
                    state_next    = S_DONE;
                end else begin
                    cmd.ptr_wrap_step = 1'b1;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
